// File: rtl/mcdt_pkg.sv
// Constants and helpers shared by the MIDI clock divider and tempo meter.
package mcdt_pkg;

    localparam int unsigned PULSES_PER_QUARTER = 24;
    localparam int unsigned COUNT_W            = 5;
    localparam int unsigned TIME_W             = 32;
    localparam int unsigned TEMPO_W            = 24;
    localparam int unsigned BYTE_W             = 8;
    localparam int unsigned SEL_W              = 3;

    localparam logic [BYTE_W-1:0]  CLOCK_BYTE    = 8'hF8;
    // 60000 ms per minute, scaled by 2^8 for the Q.8 result
    localparam logic [TEMPO_W-1:0] TEMPO_DIVIDEND = 24'd15360000;

    localparam logic [COUNT_W-1:0] LAST_COUNT = COUNT_W'(PULSES_PER_QUARTER - 1);
    localparam logic [COUNT_W-1:0] TOP_BIT    = COUNT_W'(TEMPO_W - 1);

    typedef enum logic [SEL_W-1:0] {
        DIV_EVERY   = 3'd0,
        DIV_QUARTER = 3'd1,
        DIV_EIGHTH  = 3'd2,
        DIV_SIXTEENTH = 3'd3,
        DIV_THIRTY_SECOND = 3'd4
    } division_t;

    localparam logic CMD_BYTE  = 1'b0;
    localparam logic CMD_RESET = 1'b1;

    // True when the clock count falls on the selected division.
    function automatic logic on_division(input logic [SEL_W-1:0] sel,
                                         input logic [COUNT_W-1:0] count);
        logic hit;
        begin
            case (sel)
                DIV_EVERY:     hit = 1'b1;
                DIV_QUARTER:   hit = (count == 5'd0);
                DIV_EIGHTH:    hit = (count == 5'd0) || (count == 5'd12);
                DIV_SIXTEENTH: hit = (count == 5'd0) || (count == 5'd6) ||
                                     (count == 5'd12) || (count == 5'd18);
                default:       hit = (count == 5'd0) || (count == 5'd3) ||
                                     (count == 5'd6) || (count == 5'd9) ||
                                     (count == 5'd12) || (count == 5'd15) ||
                                     (count == 5'd18) || (count == 5'd21);
            endcase
            return hit;
        end
    endfunction

endpackage

// File: rtl/midi_clock_divider_tempo_top.sv
// Top level: MIDI 24 ppqn clock divider with serial tempo divider.
//
// Input stream s_axis: one transaction per MIDI byte. tuser is the command
// (0 received byte, 1 clear the clock count); tdata carries the byte and its
// millisecond timestamp. Only the timing-clock byte 0xF8 acts.
// Output stream m_axis: one transaction per beat pulse of the division set on
// the configuration port. tuser carries the pulse flag and tempo valid flag,
// tdata the tempo in beats per minute, unsigned Q.8 (all ones when the
// elapsed time is zero).
// A pulse without a tempo goes from acceptance through ST_EMIT to the output
// register. A quarter note that carries a tempo first runs a restoring divider
// in ST_DIV that yields one quotient bit per cycle, for all 24 dividend bits.
// Items are taken one at a time: bytes with no result are taken one per cycle,
// while a byte that yields a pulse holds off the next until it leaves ST_EMIT.
// A waiting result sits in the output register while the next item is taken;
// a stalled receiver holds the next result in ST_EMIT, and no input is taken.
// Reset clears the count, the previous-time flag, the division setting and
// the output valid.
module midi_clock_divider_tempo_top
    import mcdt_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_wr_en,
    input  logic [SEL_W-1:0]        cfg_wr_data,     // division_select
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [39:0]             s_axis_tdata,    // [7:0] midi_byte, [39:8] time_ms
    input  logic                    s_axis_tuser,    // [0] cmd
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [23:0]             m_axis_tdata,    // [23:0] tempo_bpm_q8
    output logic [1:0]              m_axis_tuser     // [0] beat_pulse, [1] tempo_valid
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_EMIT
    } state_t;

    state_t               state_reg, state_next;
    logic [SEL_W-1:0]     div_sel_reg, div_sel_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [TIME_W-1:0]    last_time_reg, last_time_next;
    logic                 last_valid_reg, last_valid_next;
    logic [TIME_W-1:0]    divisor_reg, divisor_next;
    logic [TIME_W-1:0]    rem_reg, rem_next;
    logic [TEMPO_W-1:0]   quot_reg, quot_next;
    logic [COUNT_W-1:0]   bit_reg, bit_next;
    logic                 tv_reg, tv_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_tv_reg, out_tv_next;
    logic [TEMPO_W-1:0]   out_tempo_reg, out_tempo_next;

    logic                 accept;
    logic [BYTE_W-1:0]    in_byte;
    logic [TIME_W-1:0]    in_time;
    logic [TIME_W:0]      rem_shift;
    logic [TIME_W:0]      rem_diff;
    logic                 out_free;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign in_byte       = s_axis_tdata[7:0];
    assign in_time       = s_axis_tdata[39:8];
    assign out_free      = !out_valid_reg || m_axis_tready;

    // One restoring step: bring down the next dividend bit, subtract if it fits.
    // A zero divisor gives all ones, which is the saturated tempo.
    assign rem_shift = {rem_reg, TEMPO_DIVIDEND[bit_reg]};
    assign rem_diff  = rem_shift - {1'b0, divisor_reg};

    always_comb
    begin
        state_next      = state_reg;
        div_sel_next    = div_sel_reg;
        count_next      = count_reg;
        last_time_next  = last_time_reg;
        last_valid_next = last_valid_reg;
        divisor_next    = divisor_reg;
        rem_next        = rem_reg;
        quot_next       = quot_reg;
        bit_next        = bit_reg;
        tv_next         = tv_reg;
        out_valid_next  = out_valid_reg;
        out_tv_next     = out_tv_reg;
        out_tempo_next  = out_tempo_reg;

        if (cfg_wr_en)
        begin
            div_sel_next = cfg_wr_data;
        end

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (s_axis_tuser == CMD_RESET)
                    begin
                        count_next = '0;
                    end
                    else if (in_byte == CLOCK_BYTE)
                    begin
                        tv_next      = (count_reg == '0) && last_valid_reg;
                        divisor_next = in_time - last_time_reg;
                        rem_next     = '0;
                        quot_next    = '0;
                        bit_next     = TOP_BIT;
                        if (count_reg == '0)
                        begin
                            last_time_next  = in_time;
                            last_valid_next = 1'b1;
                        end
                        count_next = (count_reg == LAST_COUNT) ? '0 : count_reg + 1'b1;
                        // drop clocks that miss the division
                        if (on_division(div_sel_reg, count_reg))
                        begin
                            if ((count_reg == '0) && last_valid_reg)
                            begin
                                state_next = ST_DIV;
                            end
                            else
                            begin
                                state_next = ST_EMIT;
                            end
                        end
                    end
                end
            end
            ST_DIV:
            begin
                if (!rem_diff[TIME_W])
                begin
                    rem_next  = rem_diff[TIME_W-1:0];
                    quot_next = {quot_reg[TEMPO_W-2:0], 1'b1};
                end
                else
                begin
                    rem_next  = rem_shift[TIME_W-1:0];
                    quot_next = {quot_reg[TEMPO_W-2:0], 1'b0};
                end
                bit_next = bit_reg - 1'b1;
                if (bit_reg == '0)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                // hold until the output register is free
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_tv_next    = tv_reg;
                    out_tempo_next = tv_reg ? quot_reg : '0;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            div_sel_reg    <= '0;
            count_reg      <= '0;
            last_time_reg  <= '0;
            last_valid_reg <= 1'b0;
            divisor_reg    <= '0;
            rem_reg        <= '0;
            quot_reg       <= '0;
            bit_reg        <= '0;
            tv_reg         <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_tv_reg     <= 1'b0;
            out_tempo_reg  <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            div_sel_reg    <= div_sel_next;
            count_reg      <= count_next;
            last_time_reg  <= last_time_next;
            last_valid_reg <= last_valid_next;
            divisor_reg    <= divisor_next;
            rem_reg        <= rem_next;
            quot_reg       <= quot_next;
            bit_reg        <= bit_next;
            tv_reg         <= tv_next;
            out_valid_reg  <= out_valid_next;
            out_tv_reg     <= out_tv_next;
            out_tempo_reg  <= out_tempo_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tempo_reg;
    assign m_axis_tuser  = {out_tv_reg, 1'b1};

endmodule
